// ===== sv/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; every other file imports this package.
package pva_pkg;

  // Default voice count of the allocator
  localparam int unsigned NUM_VOICES_DEF = 8;

  // Beat field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned FIN_W   = 3;
  localparam int unsigned VOICE_W = 3;
  localparam int unsigned MASK_W  = 8;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    F_NOTE_ON  = 2'd0,
    F_NOTE_OFF = 2'd1,
    F_ALL_OFF  = 2'd2,
    F_FINISHED = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Per-voice key held in the note/channel memory
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] channel;
  } entry_t;

endpackage

// ===== sv/pva_if.sv =====
// Valid/ready channel interfaces for the voice allocator request and response.
// Depends on pva_pkg for the field widths.
interface pva_req_if;
  import pva_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAN_W-1:0] midi_channel;
  logic [NOTE_W-1:0] note;
  logic [FIN_W-1:0]  finished_voice;

  modport source (output valid, func, midi_channel, note, finished_voice, input ready);
  modport sink   (input valid, func, midi_channel, note, finished_voice, output ready);
endinterface

interface pva_rsp_if;
  import pva_pkg::*;
  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice;
  logic               hit;
  logic               stolen;
  logic [MASK_W-1:0]  released_mask;
  logic [MASK_W-1:0]  live_mask;

  modport source (output valid, voice, hit, stolen, released_mask, live_mask, input ready);
  modport sink   (input valid, voice, hit, stolen, released_mask, live_mask, output ready);
endinterface

// ===== sv/pva_cmp.sv =====
// Shared compare unit: tests one voice entry against the request key.
// Depends on pva_pkg.
module pva_cmp (
  input  pva_pkg::func_t  mode,
  input  logic            live,
  input  logic            keydown,
  input  pva_pkg::entry_t entry,
  input  pva_pkg::entry_t key,
  output logic            match
);
  import pva_pkg::*;

  // Note-on looks for a free voice, note-off for a held voice with the same key
  always_comb begin
    case (mode)
      F_NOTE_ON:  match = !live;
      F_NOTE_OFF: match = live && keydown && (entry == key);
      default:    match = 1'b0;
    endcase
  end

endmodule

// ===== sv/poly_voice_allocator.sv =====
// Note on / note off scan the voices between accept and result beat (one voice tested per
// cycle by a shared compare unit, fed by a registered memory read). All notes off and voice
// finished go straight to the result beat. One request is in flight at a time;
// the next is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears live and key-down flags, the steal pointer,
// the sequencer and the output valid; the note/channel memory is not cleared.
module poly_voice_allocator #(
  parameter int unsigned NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  pva_req_if.sink   req,
  pva_rsp_if.source rsp
);
  import pva_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned LW = (NUM_VOICES > MASK_W) ? NUM_VOICES : MASK_W;
  localparam logic [VW-1:0] LAST = VW'(NUM_VOICES - 1);

  state_t state, state_next;

  logic [NUM_VOICES-1:0] live, keydown;
  logic [VW-1:0]         steal_ptr;
  entry_t                mem [NUM_VOICES];

  // Scan sequencer
  logic [VW-1:0] idx, rd_idx;
  logic          issue_done, rd_vld;
  entry_t        rd_word;
  func_t         cmd;
  entry_t        key;

  // Held result of the current request
  logic [VW-1:0]     r_voice;
  logic              r_hit, r_stolen;
  logic [MASK_W-1:0] r_rel;

  // Decision controls
  logic          start, dec, dec_hit, dec_steal, load_out, match;
  logic [VW-1:0] dec_voice;

  logic [LW-1:0]     live_pad;
  logic [6:0]        dv7, rv7, fin7;
  logic              fin_ok;
  logic [VW-1:0]     fin_idx;
  logic [MASK_W-1:0] rel_oh;

  assign live_pad = LW'(live);
  assign dv7      = 7'(dec_voice);
  assign rv7      = 7'(r_voice);
  assign rel_oh   = (dv7 < 7'd8) ? (MASK_W'(1) << dv7[2:0]) : '0;
  assign fin7     = {4'b0, req.finished_voice};
  assign fin_ok   = fin7 < 7'(NUM_VOICES);
  assign fin_idx  = VW'(fin7);

  pva_cmp u_cmp (
    .mode    (cmd),
    .live    (live[rd_idx]),
    .keydown (keydown[rd_idx]),
    .entry   (rd_word),
    .key     (key),
    .match   (match)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and step controls
  always_comb begin
    state_next = state;
    start      = 1'b0;
    dec        = 1'b0;
    dec_hit    = 1'b0;
    dec_steal  = 1'b0;
    dec_voice  = '0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          start      = 1'b1;
          state_next = (req.func inside {F_NOTE_ON, F_NOTE_OFF}) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (rd_vld && match) begin
          dec        = 1'b1;
          dec_hit    = 1'b1;
          dec_voice  = rd_idx;
          state_next = S_EMIT;
        end else if (rd_vld && rd_idx == LAST) begin
          // nothing matched: note-on steals at the pointer, note-off misses
          dec        = 1'b1;
          if (cmd == F_NOTE_ON) begin
            dec_hit   = 1'b1;
            dec_steal = 1'b1;
            dec_voice = steal_ptr;
          end
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // Note/channel memory: one read port for the scan, one write port
  always_ff @(posedge clk) begin
    rd_word <= mem[idx];
    rd_idx  <= idx;
    if (dec && dec_hit && cmd == F_NOTE_ON) mem[dec_voice] <= key;
  end

  // Scan address counter and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN) && !issue_done && !dec;
    end
    if (start) begin
      idx        <= '0;
      issue_done <= 1'b0;
      cmd        <= func_t'(req.func);
      key        <= '{note: req.note, channel: req.midi_channel};
    end else if (state == S_SCAN && !issue_done) begin
      idx <= (idx == LAST) ? idx : idx + 1'b1;
      if (idx == LAST) issue_done <= 1'b1;
    end
  end

  // Voice flags, steal pointer and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      keydown   <= '0;
      steal_ptr <= '0;
    end else begin
      if (start) begin
        r_voice  <= '0;
        r_hit    <= 1'b0;
        r_stolen <= 1'b0;
        case (func_t'(req.func))
          F_ALL_OFF: begin
            r_rel   <= live_pad[MASK_W-1:0];
            live    <= '0;
            keydown <= '0;
          end
          F_FINISHED: begin
            r_rel <= '0;
            if (fin_ok) begin
              live[fin_idx]    <= 1'b0;
              keydown[fin_idx] <= 1'b0;
            end
          end
          default: r_rel <= '0;
        endcase
      end
      if (dec) begin
        r_voice  <= dec_voice;
        r_hit    <= dec_hit;
        r_stolen <= dec_steal;
        r_rel    <= (dec_hit && (cmd == F_NOTE_OFF || dec_steal)) ? rel_oh : '0;
        if (cmd == F_NOTE_ON) begin
          live[dec_voice]    <= 1'b1;
          keydown[dec_voice] <= 1'b1;
          if (dec_steal) steal_ptr <= (steal_ptr == LAST) ? '0 : steal_ptr + 1'b1;
        end else if (dec_hit) begin
          keydown[dec_voice] <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (load_out) begin
      rsp.voice         <= rv7[VOICE_W-1:0];
      rsp.hit           <= r_hit;
      rsp.stolen        <= r_stolen;
      rsp.released_mask <= r_rel;
      rsp.live_mask     <= live_pad[MASK_W-1:0];
    end
  end

endmodule

// ===== sv/pva_checker.sv =====
// Port-level checks for poly_voice_allocator, attached by bind.
// Depends on pva_pkg and the top level's channel ports.
module pva_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [pva_pkg::VOICE_W-1:0] voice,
  input logic                       hit,
  input logic                       stolen,
  input logic [pva_pkg::MASK_W-1:0]  released_mask,
  input logic [pva_pkg::MASK_W-1:0]  live_mask
);
  import pva_pkg::*;

  // A stalled result beat stays valid with its released and live masks unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(released_mask) && $stable(live_mask))
    else $error("result beat changed while stalled");

  // Busy after taking a request beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a request is in flight");

  // A steal is always an allocation
  a_steal_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && stolen |-> hit)
    else $error("steal reported without allocation");

  // A stolen voice is retriggered, so every released voice is live again and at most one is released
  a_steal_live: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && stolen |-> (released_mask & ~live_mask) == '0 && $onehot0(released_mask))
    else $error("stolen voice not live after retrigger");

  // No result beat straight after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result beat valid after reset");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .voice         (rsp.voice),
  .hit           (rsp.hit),
  .stolen        (rsp.stolen),
  .released_mask (rsp.released_mask),
  .live_mask     (rsp.live_mask)
);
